/* design/text_console_writer_macros.svh */
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// condition holds at every clock edge out of reset
`define TCW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TCW_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* design/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, character codes, command word and sequencer state types.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam int FUNC_W = 2;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 2 * CHAR_W;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] DEFAULT_ATTR = 8'h07;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_NOP,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] attr;
    logic [ADDR_W-1:0] raddr;
  } cmd_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_DRAIN,
    S_FILL,
    S_CLEAR
  } back_state_t;

endpackage

/* design/tcw_front.sv */
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts input words and decodes them into command words for the back end.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic                        push,
  output logic                        full,
  input  logic [tcw_pkg::FUNC_W-1:0]  func,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcw_pkg::CHAR_W-1:0]  attr,
  input  logic [tcw_pkg::COL_W-1:0]   read_col,
  input  logic [tcw_pkg::ROW_W-1:0]   read_row,
  input  logic                        q_full,
  input  logic                        init_busy,
  output logic                        q_push,
  output tcw_pkg::cmd_t               q_wdata
);
  import tcw_pkg::*;

  logic in_range;

  // no words taken while the screen is being cleared after reset
  assign full   = q_full | init_busy;
  assign q_push = push & ~full;

  assign in_range = (read_col < COL_W'(COLS)) && (read_row < ROW_W'(ROWS));

  always_comb begin
    q_wdata.ch    = char_code;
    q_wdata.attr  = attr;
    q_wdata.raddr = ADDR_W'(read_row) * ADDR_W'(COLS) + ADDR_W'(read_col);
    unique case (func_t'(func))
      FUNC_PUT: begin
        if (char_code == CH_NEWLINE) begin
          q_wdata.op = OP_NEWLINE;
        end else if (char_code == CH_BACKSPACE) begin
          q_wdata.op = OP_BACKSPACE;
        end else if (char_code == CH_TAB) begin
          q_wdata.op = OP_NOP;
        end else begin
          q_wdata.op = OP_PUT;
        end
      end
      FUNC_CLEAR: q_wdata.op = OP_CLEAR;
      FUNC_READ:  q_wdata.op = in_range ? OP_READ : OP_NOP;
      FUNC_NONE:  q_wdata.op = OP_NOP;
      default:    q_wdata.op = OP_NOP;
    endcase
  end

endmodule

/* design/tcw_cmd_queue.sv */
// ----------------------------------------------------------------------------
// Text console writer command queue
// Short FIFO of decoded command words between front and back end.
// ----------------------------------------------------------------------------
module tcw_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output tcw_pkg::cmd_t rdata,
  output logic          empty
);
  import tcw_pkg::*;

  cmd_t                entries [QDEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = entries[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/tcw_back.sv */
// ----------------------------------------------------------------------------
// Text console writer back end
// Executes command words on the screen memory and cursor, holds the result.
// ----------------------------------------------------------------------------
`include "text_console_writer_macros.svh"

module tcw_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  tcw_pkg::cmd_t              q_rdata,
  output logic                       q_pop,
  output logic                       init_busy,
  output logic                       empty,
  input  logic                       pop,
  output logic [tcw_pkg::COL_W-1:0]  cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]  cursor_row,
  output logic [tcw_pkg::CHAR_W-1:0] cell_char,
  output logic [tcw_pkg::CHAR_W-1:0] cell_attr
);
  import tcw_pkg::*;

  localparam logic [CELL_W-1:0] DEFAULT_CELL = {DEFAULT_ATTR, BLANK_CHAR};
  localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_BASE  = ADDR_W'((ROWS - 1) * COLS);

  back_state_t         state, state_next;
  logic [ADDR_W-1:0]   swp, swp_next;
  logic [COL_W-1:0]    cur_col, cur_col_next;
  logic [ROW_W-1:0]    cur_row, cur_row_next;
  logic [ADDR_W-1:0]   cur_base, cur_base_next;
  logic [CHAR_W-1:0]   fill_attr, fill_attr_next;
  logic                cp_pend;
  logic [ADDR_W-1:0]   cp_addr;

  logic                res_valid;
  logic                emit;
  logic [CHAR_W-1:0]   emit_char;
  logic [CHAR_W-1:0]   emit_attr;

  logic [CELL_W-1:0]   mem [CELLS];
  logic [CELL_W-1:0]   rdata;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [ADDR_W-1:0]   cur_addr;

  assign init_busy = (state == S_INIT);
  assign empty     = ~res_valid;
  assign cur_addr  = cur_base + ADDR_W'(cur_col);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      swp       <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      cur_base  <= '0;
      cp_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      swp       <= swp_next;
      cur_col   <= cur_col_next;
      cur_row   <= cur_row_next;
      cur_base  <= cur_base_next;
      cp_pend   <= (state == S_SCROLL);
      res_valid <= emit | (res_valid & ~pop);
    end
  end

  always_ff @(posedge clk) begin
    fill_attr <= fill_attr_next;
    cp_addr   <= swp - ADDR_W'(COLS);
    if (emit) begin
      cursor_col <= cur_col_next;
      cursor_row <= cur_row_next;
      cell_char  <= emit_char;
      cell_attr  <= emit_attr;
    end
  end

  always_comb begin
    state_next     = state;
    swp_next       = swp;
    cur_col_next   = cur_col;
    cur_row_next   = cur_row;
    cur_base_next  = cur_base;
    fill_attr_next = fill_attr;
    q_pop          = 1'b0;
    emit           = 1'b0;
    emit_char      = '0;
    emit_attr      = '0;
    mem_we         = 1'b0;
    mem_waddr      = swp;
    mem_wdata      = DEFAULT_CELL;
    mem_re         = 1'b0;
    mem_raddr      = swp;

    unique case (state)
      S_INIT: begin
        mem_we = 1'b1;
        if (swp == LAST_ADDR) begin
          swp_next   = '0;
          state_next = S_IDLE;
        end else begin
          swp_next = swp + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        if (!q_empty && !res_valid) begin
          q_pop = 1'b1;
          unique case (q_rdata.op)
            OP_PUT, OP_NEWLINE: begin
              if (q_rdata.op == OP_PUT) begin
                mem_we    = 1'b1;
                mem_waddr = cur_addr;
                mem_wdata = {q_rdata.attr, q_rdata.ch};
              end
              if (q_rdata.op == OP_PUT && cur_col != COL_W'(COLS - 1)) begin
                cur_col_next = cur_col + COL_W'(1);
                emit         = 1'b1;
              end else if (cur_row == ROW_W'(ROWS - 1)) begin
                // leaving the bottom row: copy rows up, then blank the last
                cur_col_next   = '0;
                fill_attr_next = q_rdata.attr;
                swp_next       = ADDR_W'(COLS);
                state_next     = S_SCROLL;
              end else begin
                cur_col_next  = '0;
                cur_row_next  = cur_row + ROW_W'(1);
                cur_base_next = cur_base + ADDR_W'(COLS);
                emit          = 1'b1;
              end
            end
            OP_BACKSPACE: begin
              if (cur_col != '0) begin
                cur_col_next = cur_col - COL_W'(1);
                mem_we       = 1'b1;
                mem_waddr    = cur_addr - ADDR_W'(1);
                mem_wdata    = {q_rdata.attr, BLANK_CHAR};
              end
              emit = 1'b1;
            end
            OP_NOP: begin
              emit = 1'b1;
            end
            OP_CLEAR: begin
              cur_col_next  = '0;
              cur_row_next  = '0;
              cur_base_next = '0;
              swp_next      = '0;
              state_next    = S_CLEAR;
            end
            OP_READ: begin
              mem_re     = 1'b1;
              mem_raddr  = q_rdata.raddr;
              state_next = S_READ;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        emit       = 1'b1;
        emit_char  = rdata[CHAR_W-1:0];
        emit_attr  = rdata[CELL_W-1:CHAR_W];
        state_next = S_IDLE;
      end

      S_SCROLL: begin
        // read one cell per cycle, write it one row up in the next cycle
        mem_re    = 1'b1;
        mem_raddr = swp;
        mem_we    = cp_pend;
        mem_waddr = cp_addr;
        mem_wdata = rdata;
        if (swp == LAST_ADDR) begin
          state_next = S_DRAIN;
        end else begin
          swp_next = swp + ADDR_W'(1);
        end
      end

      S_DRAIN: begin
        mem_we     = cp_pend;
        mem_waddr  = cp_addr;
        mem_wdata  = rdata;
        swp_next   = BOTTOM_BASE;
        state_next = S_FILL;
      end

      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {fill_attr, BLANK_CHAR};
        if (swp == LAST_ADDR) begin
          cur_col_next  = '0;
          cur_row_next  = ROW_W'(ROWS - 1);
          cur_base_next = BOTTOM_BASE;
          swp_next      = '0;
          emit          = 1'b1;
          state_next    = S_IDLE;
        end else begin
          swp_next = swp + ADDR_W'(1);
        end
      end

      S_CLEAR: begin
        mem_we = 1'b1;
        if (swp == LAST_ADDR) begin
          swp_next   = '0;
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          swp_next = swp + ADDR_W'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `TCW_ASSERT_ALWAYS(a_col_range, cur_col < COL_W'(COLS), "cursor column past last column")
  `TCW_ASSERT_ALWAYS(a_base_row, cur_base == ADDR_W'(cur_row) * ADDR_W'(COLS), "row base mismatch")
  `TCW_ASSERT_IMPLY(a_init_quiet, state == S_INIT, !res_valid && !q_pop, "activity during init")
  `TCW_ASSERT_IMPLY(a_scroll_row, $rose(res_valid) && $past(state) == S_FILL, cur_row == ROW_W'(ROWS - 1), "scroll left cursor off bottom row")

endmodule

/* design/text_console_writer.sv */
// Text console writer: 80x25 cell screen with cursor, one result word per input word.
// Put, newline, backspace and no-op words act from the queue head, a read goes through
// a memory read first; clear and a scroll pass over the memory one cell per cycle.
// A new word is taken from the queue only after the single result register has been popped.
// Reset: synchronous; afterwards a pass over the screen memory blanks it, full held high.
// ----------------------------------------------------------------------------
// Text console writer top level
// Front end decoder, command queue and screen back end behind queue handshakes.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [tcw_pkg::FUNC_W-1:0] func,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tcw_pkg::CHAR_W-1:0] attr,
  input  logic [tcw_pkg::COL_W-1:0]  read_col,
  input  logic [tcw_pkg::ROW_W-1:0]  read_row,
  output logic                       empty,
  input  logic                       pop,
  output logic [tcw_pkg::COL_W-1:0]  cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]  cursor_row,
  output logic [tcw_pkg::CHAR_W-1:0] cell_char,
  output logic [tcw_pkg::CHAR_W-1:0] cell_attr
);
  import tcw_pkg::*;

  cmd_t q_wdata;
  cmd_t q_rdata;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  logic init_busy;

  tcw_front u_front (
    .push      (push),
    .full      (full),
    .func      (func),
    .char_code (char_code),
    .attr      (attr),
    .read_col  (read_col),
    .read_row  (read_row),
    .q_full    (q_full),
    .init_busy (init_busy),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  tcw_cmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  tcw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .init_busy  (init_busy),
    .empty      (empty),
    .pop        (pop),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr)
  );

endmodule
